// ----- design/tcpq_pkg.sv -----
// shared types and codes for the two-class priority queue
// no dependencies; imported by every module of the block
package tcpq_pkg;

	// one stored entry: priority and customer id
	typedef struct packed {
		logic [7:0]  prio;
		logic [31:0] id;
	} entry_t;

	// per-cell control, issued by the chain to every cell each cycle
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_POP_EMPTY  = 2'd1,
		STATUS_PUSH_FULL  = 2'd2
	} status_t;

	localparam logic [7:0] VIP_PRIO = 8'd1;

	localparam int unsigned COUNT_OUT_W = 6;

endpackage

// ----- design/tcpq_cell.sv -----
// one storage cell of a class chain
// depends on tcpq_pkg
module tcpq_cell (
	input  logic                clk,
	input  tcpq_pkg::cell_ctrl_t ctrl,
	input  tcpq_pkg::entry_t    new_entry,
	input  tcpq_pkg::entry_t    next_entry,
	output tcpq_pkg::entry_t    entry_q
);
	import tcpq_pkg::*;

	// payload only, no reset: a cell is read only below the fill count
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= new_entry;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ----- design/tcpq_class_chain.sv -----
// first-in first-out store of one class, built as a row of shifting cells
// depends on tcpq_pkg and tcpq_cell
module tcpq_class_chain #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           pop,
	input  tcpq_pkg::entry_t               new_entry,
	output tcpq_pkg::entry_t               head_entry,
	output logic [$clog2(DEPTH+1)-1:0]     count,
	output logic                           full
);
	import tcpq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	entry_t        cell_data [DEPTH];
	cell_ctrl_t    cell_ctrl [DEPTH];

	assign full  = (count_q == CW'(DEPTH));
	assign count = count_q;
	assign head_entry = cell_data[0];

	// count of live cells; push and pop never come together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push && !full) begin
			count_q <= count_q + CW'(1);
		end else if (pop && (count_q != '0)) begin
			count_q <= count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t next_data;

		// a push lands in the first free cell, a pop moves everything one cell headward
		assign cell_ctrl[i].load  = push && !full && (count_q == CW'(i));
		assign cell_ctrl[i].shift = pop;

		if (i < DEPTH - 1) begin : g_mid
			assign next_data = cell_data[i+1];
		end else begin : g_last
			assign next_data = new_entry;
		end

		tcpq_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[i]),
			.new_entry  (new_entry),
			.next_entry (next_data),
			.entry_q    (cell_data[i])
		);
	end

endmodule

// ----- design/two_class_priority_queue.sv -----
// top level of the two-class priority queue
// depends on tcpq_pkg and tcpq_class_chain (which uses tcpq_cell)

// A queue of customer entries in two classes, each held in a first-in, first-out
// chain of CLASS_DEPTH cells. A push (func 0) with priority 1 joins the VIP chain,
// any other priority joins the normal chain; a pop (func 1) removes the oldest VIP
// entry, or the oldest normal entry when no VIP entry is held. Every item gives one
// result: head priority and id (0 when empty), entry count, empty flag and status
// (1 for a pop on an empty queue, 2 for a push into a full class; nothing changes
// then). Unless stalled, it takes one item per cycle: an item updates the cell
// chains at the edge it is accepted, and its result is shown from the next cycle
// until taken. A pop moves every cell of a chain one place toward the head, so the
// head is always read from the first cell. in_stall rises only while a result is
// held back by out_stall. There is no clearing pass: the fill counts reset, the cells do not.
module two_class_priority_queue #(
	parameter int unsigned CLASS_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input item
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  priority_req,
	input  logic [31:0] customer_id,
	// result item
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  head_priority,
	output logic [31:0] head_id,
	output logic [5:0]  entry_count,
	output logic        is_empty,
	output logic [1:0]  status
);
	import tcpq_pkg::*;

	localparam int unsigned CW = $clog2(CLASS_DEPTH + 1);

	logic          in_acc;
	logic          is_push;
	logic          is_pop;
	logic          to_vip;
	logic          vip_push;
	logic          nrm_push;
	logic          vip_pop;
	logic          nrm_pop;
	entry_t        new_entry;
	entry_t        vip_head;
	entry_t        nrm_head;
	logic [CW-1:0] vip_cnt;
	logic [CW-1:0] nrm_cnt;
	logic          vip_full;
	logic          nrm_full;
	logic [31:0]   total_wide;
	status_t       status_d;
	status_t       status_q;
	logic          out_valid_q;

	// hold input only while a finished result waits on the output side
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign is_push = in_acc && (func_t'(func) == FUNC_PUSH);
	assign is_pop  = in_acc && (func_t'(func) == FUNC_POP);
	assign to_vip  = (priority_req == VIP_PRIO);

	// chains ignore a push when full, so the error push needs no extra gating
	assign vip_push = is_push && to_vip;
	assign nrm_push = is_push && !to_vip;

	// vip entries always leave first
	assign vip_pop = is_pop && (vip_cnt != '0);
	assign nrm_pop = is_pop && (vip_cnt == '0) && (nrm_cnt != '0);

	assign new_entry.prio = priority_req;
	assign new_entry.id   = customer_id;

	tcpq_class_chain #(
		.DEPTH (CLASS_DEPTH)
	) u_vip_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (vip_push),
		.pop        (vip_pop),
		.new_entry  (new_entry),
		.head_entry (vip_head),
		.count      (vip_cnt),
		.full       (vip_full)
	);

	tcpq_class_chain #(
		.DEPTH (CLASS_DEPTH)
	) u_nrm_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (nrm_push),
		.pop        (nrm_pop),
		.new_entry  (new_entry),
		.head_entry (nrm_head),
		.count      (nrm_cnt),
		.full       (nrm_full)
	);

	// status of the item being accepted
	always_comb begin
		status_d = STATUS_OK;
		if (is_pop && (vip_cnt == '0) && (nrm_cnt == '0)) begin
			status_d = STATUS_POP_EMPTY;
		end else if (is_push && (to_vip ? vip_full : nrm_full)) begin
			status_d = STATUS_PUSH_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= STATUS_OK;
		end else begin
			if (in_acc) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result fields come straight from the chain state, which holds while stalled
	always_comb begin
		head_priority = '0;
		head_id       = '0;
		if (vip_cnt != '0) begin
			head_priority = vip_head.prio;
			head_id       = vip_head.id;
		end else if (nrm_cnt != '0) begin
			head_priority = nrm_head.prio;
			head_id       = nrm_head.id;
		end
	end

	// total wraps at six bits only for class depths above 31
	assign total_wide  = 32'(vip_cnt) + 32'(nrm_cnt);
	assign entry_count = total_wide[COUNT_OUT_W-1:0];
	assign is_empty    = (vip_cnt == '0) && (nrm_cnt == '0);
	assign status      = status_q;
	assign out_valid   = out_valid_q;

endmodule
